// ===== hdl/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the dense layer lanes
// Widths of the fixed-point datapath and the lane control word.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int MAX_LANES  = 8;
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 48;
    localparam int FRAC_BITS  = 11;
    localparam int ACT_W      = 15;
    localparam int LANE_IDX_W = $clog2(MAX_LANES);
    localparam int CFG_IDX_W  = LANE_IDX_W + 1;

    typedef struct packed {
        logic load_prod;
        logic load_acc;
        logic at_start;
    } lane_ctrl_t;

endpackage

// ===== hdl/dense_layer_relu_lanes.sv =====
// ----------------------------------------------------------------------------
// dense_layer_relu_lanes: dense layer neurons with ReLU, one lane per neuron
// A last element goes through product, accumulator and output registers.
// Throughput: one element word per cycle; each lane has one multiplier and one
// accumulator, so the input stalls only while a finished sum waits behind a
// stalled output word.
// Reset clears the pipeline valid flags and the biases, and starts a new sample.
// ----------------------------------------------------------------------------
module dense_layer_relu_lanes
    import dlr_pkg::*;
#(
    parameter int LANES = MAX_LANES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [DATA_W-1:0]    x_value,
    input  logic                        sample_valid,
    input  logic                        last_element,
    input  logic signed [DATA_W-1:0]    w_lane0,
    input  logic signed [DATA_W-1:0]    w_lane1,
    input  logic signed [DATA_W-1:0]    w_lane2,
    input  logic signed [DATA_W-1:0]    w_lane3,
    input  logic signed [DATA_W-1:0]    w_lane4,
    input  logic signed [DATA_W-1:0]    w_lane5,
    input  logic signed [DATA_W-1:0]    w_lane6,
    input  logic signed [DATA_W-1:0]    w_lane7,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ACT_W-1:0]            act_lane0,
    output logic [ACT_W-1:0]            act_lane1,
    output logic [ACT_W-1:0]            act_lane2,
    output logic [ACT_W-1:0]            act_lane3,
    output logic [ACT_W-1:0]            act_lane4,
    output logic [ACT_W-1:0]            act_lane5,
    output logic [ACT_W-1:0]            act_lane6,
    output logic [ACT_W-1:0]            act_lane7,
    output logic                        valid_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data
);

    logic signed [DATA_W-1:0]          w_arr [MAX_LANES];
    logic [MAX_LANES-1:0][DATA_W-1:0]  bias_reg;
    logic [MAX_LANES-1:0][ACC_W-1:0]   acc_all;
    logic [MAX_LANES-1:0][ACT_W-1:0]   act_all;
    lane_ctrl_t                        ctrl;
    logic                              a_valid_reg;
    logic                              a_last_reg;
    logic                              a_sv_reg;
    logic                              fin_reg;
    logic                              b_sv_reg;
    logic                              at_start_reg;
    logic                              hold;
    logic                              load_in;
    logic                              advance;

    assign w_arr[0] = w_lane0;
    assign w_arr[1] = w_lane1;
    assign w_arr[2] = w_lane2;
    assign w_arr[3] = w_lane3;
    assign w_arr[4] = w_lane4;
    assign w_arr[5] = w_lane5;
    assign w_arr[6] = w_lane6;
    assign w_arr[7] = w_lane7;

    assign cfg_ready = 1'b1;
    assign in_stall  = hold;
    assign advance   = !hold;
    assign load_in   = in_valid && !hold;

    assign ctrl.load_prod = load_in;
    assign ctrl.load_acc  = a_valid_reg && advance;
    assign ctrl.at_start  = at_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(MAX_LANES)))
        begin
            bias_reg[cfg_index[LANE_IDX_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            fin_reg      <= 1'b0;
            at_start_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= load_in;
            fin_reg     <= a_valid_reg && a_last_reg;
            if (a_valid_reg)
            begin
                at_start_reg <= a_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            a_last_reg <= last_element;
            a_sv_reg   <= sample_valid;
        end
        if (advance)
        begin
            b_sv_reg <= a_sv_reg;
        end
    end

    for (genvar g = 0; g < MAX_LANES; g++)
    begin : g_lane
        if (g < LANES)
        begin : g_on
            dlr_lane u_lane (
                .clk     (clk),
                .ctrl    (ctrl),
                .x_value (x_value),
                .w_value (w_arr[g]),
                .bias    (bias_reg[g]),
                .acc     (acc_all[g])
            );
        end
        else
        begin : g_off
            assign acc_all[g] = '0;
        end
    end

    dlr_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .fin          (fin_reg),
        .sample_valid (b_sv_reg),
        .acc          (acc_all),
        .out_stall    (out_stall),
        .hold         (hold),
        .out_valid    (out_valid),
        .act          (act_all),
        .valid_out    (valid_out)
    );

    assign act_lane0 = act_all[0];
    assign act_lane1 = act_all[1];
    assign act_lane2 = act_all[2];
    assign act_lane3 = act_all[3];
    assign act_lane4 = act_all[4];
    assign act_lane5 = act_all[5];
    assign act_lane6 = act_all[6];
    assign act_lane7 = act_all[7];

    // A finished sum held behind a stalled output word must not be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> fin_reg && $stable(acc_all))
        else $error("held lane sums changed");

    // A masked sample gives an all-zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_out) |-> (act_all == '0))
        else $error("masked sample gave non-zero activations");

    // A last element that leaves the product stage becomes a finished sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_last_reg && advance) |=> fin_reg && at_start_reg)
        else $error("last element did not close the sample");

endmodule

// ===== hdl/dlr_lane.sv =====
// ----------------------------------------------------------------------------
// dlr_lane: one neuron lane
// Registered multiply followed by a saturating 48-bit accumulate.
// ----------------------------------------------------------------------------
module dlr_lane
    import dlr_pkg::*;
(
    input  logic                     clk,
    input  lane_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] x_value,
    input  logic signed [DATA_W-1:0] w_value,
    input  logic        [DATA_W-1:0] bias,
    output logic        [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic        [ACC_W-1:0]  acc_reg;
    logic        [ACC_W-1:0]  acc_next;
    logic        [ACC_W-1:0]  bias_ext;
    logic        [ACC_W-1:0]  base;
    logic        [ACC_W:0]    sum;

    assign bias_ext = {{(ACC_W - DATA_W){bias[DATA_W-1]}}, bias};
    assign base     = ctrl.at_start ? (bias_ext << FRAC_BITS) : acc_reg;
    assign sum      = {base[ACC_W-1], base}
                    + {{(ACC_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_reg <= x_value * w_value;
        end
        if (ctrl.load_acc)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/dlr_merge.sv =====
// ----------------------------------------------------------------------------
// dlr_merge: activation and output register
// Applies ReLU, rescaling and saturation to every lane sum and holds the word.
// ----------------------------------------------------------------------------
module dlr_merge
    import dlr_pkg::*;
#(
    parameter int LANES = MAX_LANES
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fin,
    input  logic                                sample_valid,
    input  logic [MAX_LANES-1:0][ACC_W-1:0]     acc,
    input  logic                                out_stall,
    output logic                                hold,
    output logic                                out_valid,
    output logic [MAX_LANES-1:0][ACT_W-1:0]     act,
    output logic                                valid_out
);

    logic                              out_valid_reg;
    logic [MAX_LANES-1:0][ACT_W-1:0]   act_reg;
    logic [MAX_LANES-1:0][ACT_W-1:0]   act_next;
    logic                              valid_out_reg;
    logic                              load;

    assign hold = fin && out_valid_reg && out_stall;
    assign load = fin && !(out_valid_reg && out_stall);

    always_comb
    begin
        for (int k = 0; k < MAX_LANES; k++)
        begin
            act_next[k] = '0;
            if (sample_valid && (k < LANES) && !acc[k][ACC_W-1] && (acc[k] != '0))
            begin
                if (|acc[k][ACC_W-2:FRAC_BITS+ACT_W])
                begin
                    act_next[k] = '1;
                end
                else
                begin
                    act_next[k] = acc[k][FRAC_BITS+ACT_W-1:FRAC_BITS];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            act_reg       <= act_next;
            valid_out_reg <= sample_valid;
        end
    end

    assign out_valid = out_valid_reg;
    assign act       = act_reg;
    assign valid_out = valid_out_reg;

endmodule
